### src/assert_macros.svh
// Assertion macros for the RTL in this folder.
// No dependencies; every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/prm_pkg.sv
// Package for the per-id runtime and memory monitor: request and result
// structs, request codes, register indexes and reset constants. No dependencies.
package prm_pkg;

	// Table size default
	localparam int MAX_IDS_DEF = 8;

	// Field widths
	localparam int REQ_W    = 2;
	localparam int ID_W     = 23;
	localparam int SLOT_W   = 3;
	localparam int DELTA_W  = 32;
	localparam int TICK_W   = 64;
	localparam int KB_W     = 40;
	localparam int CNT_W    = 64;
	localparam int PERIOD_W = 32;
	localparam int CFG_W    = 40;
	localparam int CFG_IDX_W = 1;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_EVENT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'd1;

	// Register reset values
	localparam logic [KB_W-1:0]     THRESHOLD_RESET = KB_W'(512 * 1024);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(1000);

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [ID_W-1:0]    proc_id;
		logic [SLOT_W-1:0]  slot_index;
		logic [DELTA_W-1:0] runtime_delta;
		logic [TICK_W-1:0]  now_tick;
		logic [KB_W-1:0]    rss_sample_kb;
	} req_t;

	typedef struct packed {
		logic              matched;
		logic              sampled;
		logic              over_threshold;
		logic [SLOT_W-1:0] slot_out;
		logic [ID_W-1:0]   id_out;
		logic [CNT_W-1:0]  runtime_total;
		logic [CNT_W-1:0]  event_total;
		logic [KB_W-1:0]   rss_last_kb;
		logic [CNT_W-1:0]  report_total;
	} rsp_t;

endpackage

### src/per_id_runtime_rss_monitor.sv
// Per-id runtime and memory monitor: id table, statistics and request handling.
// Depends on prm_pkg and assert_macros.svh.
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle unless rsp_stall holds a full result register;
// id match and slot update run in one pass through the flip-flop slot table.
// Reset clears the table, all statistics and the pipeline; registers take defaults.
`include "assert_macros.svh"

module per_id_runtime_rss_monitor #(
	parameter int MAX_IDS = prm_pkg::MAX_IDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  prm_pkg::req_t                   req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output prm_pkg::rsp_t                   rsp_data,
	input  logic                            cfg_we,
	input  logic [prm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prm_pkg::CFG_W-1:0]       cfg_data
);
	import prm_pkg::*;

	localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int EXT_W = IDX_W + SLOT_W;

	// Configuration registers
	logic [KB_W-1:0]     threshold_q;
	logic [PERIOD_W-1:0] period_q;

	// Slot table
	logic [ID_W-1:0]   id_q       [MAX_IDS];
	logic [CNT_W-1:0]  runtime_q  [MAX_IDS];
	logic [CNT_W-1:0]  events_q   [MAX_IDS];
	logic [KB_W-1:0]   rss_q      [MAX_IDS];
	logic [TICK_W-1:0] deadline_q [MAX_IDS];
	logic [CNT_W-1:0]  reports_q  [MAX_IDS];

	// Pipeline
	logic  valid_s1, valid_s2;
	req_t  req_s1;
	rsp_t  rsp_s2;
	logic  advance;
	logic  fire;

	// Request decode and slot selection
	logic [MAX_IDS-1:0] hit_vec;
	logic               found;
	logic [IDX_W-1:0]   hit_idx;
	logic [EXT_W-1:0]   slot_wide;
	logic               slot_ok;
	logic [IDX_W-1:0]   slot_idx;
	logic [IDX_W-1:0]   sel_idx;
	logic               is_event, is_set, is_clear;

	// Update values
	logic [TICK_W-1:0]  period_ext;
	logic [TICK_W-1:0]  diff;
	logic               take;
	logic               over;
	logic [CNT_W-1:0]   runtime_new;
	logic [CNT_W-1:0]   events_new;
	logic [KB_W-1:0]    rss_new;
	logic [CNT_W-1:0]   reports_new;
	rsp_t               rsp_next;

	// Handshake: the result register frees the input stage
	assign advance   = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;
	assign rsp_valid = valid_s2;
	assign rsp_data  = rsp_s2;

	// Decode request kind
	assign is_event = (req_s1.req_type == REQ_EVENT);
	assign is_set   = (req_s1.req_type == REQ_SET);
	assign is_clear = (req_s1.req_type == REQ_CLEAR);

	// Compare the id against every slot
	always_comb begin
		for (int s = 0; s < MAX_IDS; s++) begin
			hit_vec[s] = (id_q[s] == req_s1.proc_id) && (req_s1.proc_id != '0);
		end
	end

	// Pick the lowest matching slot
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int s = MAX_IDS - 1; s >= 0; s--) begin
			if (hit_vec[s]) begin
				found   = 1'b1;
				hit_idx = IDX_W'(s);
			end
		end
	end

	// Range-check the addressed slot
	assign slot_wide = {{IDX_W{1'b0}}, req_s1.slot_index};
	assign slot_ok   = slot_wide < EXT_W'(MAX_IDS);
	assign slot_idx  = slot_wide[IDX_W-1:0];
	assign sel_idx   = is_event ? hit_idx : slot_idx;

	// Sample decision: signed-wrap "after" test on the deadline
	assign period_ext  = (period_q == '0) ? TICK_W'(1) : {{(TICK_W-PERIOD_W){1'b0}}, period_q};
	assign diff        = req_s1.now_tick - deadline_q[sel_idx];
	assign take        = (diff != '0) && !diff[TICK_W-1];
	assign over        = take && (req_s1.rss_sample_kb > threshold_q);
	assign runtime_new = runtime_q[sel_idx] + {{(CNT_W-DELTA_W){1'b0}}, req_s1.runtime_delta};
	assign events_new  = events_q[sel_idx] + CNT_W'(1);
	assign rss_new     = take ? req_s1.rss_sample_kb : rss_q[sel_idx];
	assign reports_new = over ? (reports_q[sel_idx] + CNT_W'(1)) : reports_q[sel_idx];

	// Build the result
	always_comb begin
		rsp_next = '0;
		case (req_s1.req_type)
			REQ_EVENT: begin
				if (found) begin
					rsp_next.matched        = 1'b1;
					rsp_next.sampled        = take;
					rsp_next.over_threshold = over;
					rsp_next.slot_out       = SLOT_W'(hit_idx);
					rsp_next.id_out         = id_q[hit_idx];
					rsp_next.runtime_total  = runtime_new;
					rsp_next.event_total    = events_new;
					rsp_next.rss_last_kb    = rss_new;
					rsp_next.report_total   = reports_new;
				end
			end
			REQ_SET: begin
				if (slot_ok) begin
					rsp_next.matched  = 1'b1;
					rsp_next.slot_out = req_s1.slot_index;
					rsp_next.id_out   = req_s1.proc_id;
				end
			end
			REQ_CLEAR: begin
				rsp_next = '0;
			end
			REQ_READ: begin
				if (slot_ok) begin
					rsp_next.matched       = 1'b1;
					rsp_next.slot_out      = req_s1.slot_index;
					rsp_next.id_out        = id_q[slot_idx];
					rsp_next.runtime_total = runtime_q[slot_idx];
					rsp_next.event_total   = events_q[slot_idx];
					rsp_next.rss_last_kb   = rss_q[slot_idx];
					rsp_next.report_total  = reports_q[slot_idx];
				end
			end
			default: begin
				rsp_next = '0;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			period_q    <= PERIOD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_THRESHOLD) begin
				threshold_q <= cfg_data[KB_W-1:0];
			end else if (cfg_index == CFG_PERIOD) begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Pipeline payload: hold while stalled
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req_data;
		end
		if (fire) begin
			rsp_s2 <= rsp_next;
		end
	end

	// Slot table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_IDS; s++) begin
				id_q[s]       <= '0;
				runtime_q[s]  <= '0;
				events_q[s]   <= '0;
				rss_q[s]      <= '0;
				deadline_q[s] <= '0;
				reports_q[s]  <= '0;
			end
		end else if (fire) begin
			if (is_event && found) begin
				runtime_q[hit_idx] <= runtime_new;
				events_q[hit_idx]  <= events_new;
				rss_q[hit_idx]     <= rss_new;
				reports_q[hit_idx] <= reports_new;
				if (take) begin
					deadline_q[hit_idx] <= req_s1.now_tick + period_ext;
				end
			end else if (is_set && slot_ok) begin
				id_q[slot_idx]       <= req_s1.proc_id;
				runtime_q[slot_idx]  <= '0;
				events_q[slot_idx]   <= '0;
				rss_q[slot_idx]      <= '0;
				deadline_q[slot_idx] <= '0;
				reports_q[slot_idx]  <= '0;
			end else if (is_clear) begin
				for (int s = 0; s < MAX_IDS; s++) begin
					id_q[s]       <= '0;
					runtime_q[s]  <= '0;
					events_q[s]   <= '0;
					rss_q[s]      <= '0;
					deadline_q[s] <= '0;
					reports_q[s]  <= '0;
				end
			end
		end
	end

	// Checks
	`ASSERT_IMPLY(a_over_needs_sample, rsp_valid && rsp_data.over_threshold,
		rsp_data.sampled, "over_threshold without a sample")
	`ASSERT_IMPLY(a_sample_needs_match, rsp_valid && rsp_data.sampled,
		rsp_data.matched, "sample taken without a match")
	`ASSERT_ALWAYS(a_free_output_no_stall, !valid_s2 |-> !req_stall,
		"input stalled while result register empty")
	`ASSERT_NEXT(a_fire_loads_result, fire, valid_s2,
		"accepted work did not reach result register")

endmodule
